/* hdl/lpbd_pkg.sv */
package lpbd_pkg;

	localparam int unsigned WordBytes = 4;

	typedef enum logic [2:0] {
		PH_COUNT    = 3'd0,
		PH_NAME_LEN = 3'd1,
		PH_NAME     = 3'd2,
		PH_DATA_LEN = 3'd3,
		PH_DATA     = 3'd4,
		PH_DONE     = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NAME   = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_FINISH = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_COMPLETE  = 2'd0,
		ST_TRUNCATED = 2'd1,
		ST_SHORT     = 2'd2
	} status_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] acc;
		logic [1:0]  pos;
		logic [31:0] left;
		logic [31:0] total;
		logic [31:0] cur;
	} state_t;

	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [7:0]  byte_value;
		logic [31:0] entry_index;
		logic        field_last;
		logic        entry_complete;
		logic        finished;
		status_t     finish_status;
	} result_t;

	localparam state_t StateReset = '{
		phase: PH_COUNT,
		acc:   32'd0,
		pos:   2'd0,
		left:  32'd0,
		total: 32'd0,
		cur:   32'd0
	};

endpackage

/* hdl/length_prefixed_bundle_deframer.sv */
// Deframes a length-prefixed bundle arriving one byte per beat: a 32-bit
// little-endian entry count, then per entry a 32-bit name length, the name
// bytes, a 32-bit data length and the data bytes. Name and data bytes come
// out one per beat tagged with their entry index; header bytes give no beat,
// except a zero data length, which yields an empty-entry beat. The beat for
// the input marked tlast carries the finish status (complete, truncated, or
// short of the count header) and the block then starts over on a new bundle.
// On status truncated the consumer drops the open entry. One input beat is
// taken every cycle unless output backpressure stalls the input: a byte
// passes an input register, one step of phase and counter update, and an
// output register.
module length_prefixed_bundle_deframer
	import lpbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tlast,   // end_of_buffer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // byte_value, entry_index, finish_status, zero pad
	output logic [3:0]  m_tuser,   // kind, field_last, entry_complete
	output logic        m_tlast    // finished
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;
	state_t     state_q;
	state_t     state_next;
	result_t    res;
	result_t    res_q;
	logic       m_valid_q;
	logic       out_free;
	logic       advance;

	assign out_free = !m_valid_q || m_tready;
	assign advance = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eob_s1 <= s_tlast;
		end
	end

	lpbd_step u_step (
		.st            (state_q),
		.in_byte       (byte_s1),
		.end_of_buffer (eob_s1),
		.nxt           (state_next),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
			m_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (out_free) begin
				m_valid_q <= advance && res.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {6'd0, res_q.finish_status, res_q.entry_index, res_q.byte_value};
	assign m_tuser = {res_q.entry_complete, res_q.field_last, res_q.kind};
	assign m_tlast = res_q.finished;

	a_finish_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.kind == KIND_FINISH) |-> res_q.finished)
		else $error("finish-only beat without finished flag");

	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !res_q.finished) |-> (res_q.finish_status == ST_COMPLETE))
		else $error("finish status set on a beat that does not end the bundle");

	a_complete_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.entry_complete) |->
			(res_q.kind == KIND_DATA || res_q.kind == KIND_EMPTY))
		else $error("entry complete on a name or finish-only beat");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(byte_s1) && $stable(eob_s1)))
		else $error("input stage lost a byte under backpressure");

endmodule

/* hdl/lpbd_step.sv */
module lpbd_step
	import lpbd_pkg::*;
(
	input  state_t     st,
	input  logic [7:0] in_byte,
	input  logic       end_of_buffer,
	output state_t     nxt,
	output result_t    res
);

	logic [31:0] word;
	logic [31:0] left_dec;
	logic [31:0] cur_inc;
	phase_t      close_phase;
	state_t      upd;
	logic        have;

	always_comb begin
		word = st.acc;
		case (st.pos)
			2'd0: word[7:0] = st.acc[7:0] | in_byte;
			2'd1: word[15:8] = st.acc[15:8] | in_byte;
			2'd2: word[23:16] = st.acc[23:16] | in_byte;
			default: word[31:24] = st.acc[31:24] | in_byte;
		endcase
	end

	assign left_dec = st.left - 32'd1;
	assign cur_inc = st.cur + 32'd1;
	assign close_phase = (cur_inc == st.total) ? PH_DONE : PH_NAME_LEN;

	always_comb begin
		upd = st;
		have = 1'b0;
		res.kind = KIND_FINISH;
		res.byte_value = 8'd0;
		res.entry_index = st.cur;
		res.field_last = 1'b0;
		res.entry_complete = 1'b0;
		unique case (st.phase) inside
			PH_COUNT, PH_NAME_LEN, PH_DATA_LEN: begin
				upd.pos = st.pos + 2'd1;
				upd.acc = word;
				if (st.pos == 2'(WordBytes - 1)) begin
					upd.acc = 32'd0;
					if (st.phase == PH_COUNT) begin
						upd.total = word;
						upd.cur = 32'd0;
						upd.phase = (word != 32'd0) ? PH_NAME_LEN : PH_DONE;
					end else if (st.phase == PH_NAME_LEN) begin
						upd.left = word;
						upd.phase = (word != 32'd0) ? PH_NAME : PH_DATA_LEN;
					end else begin
						upd.left = word;
						if (word != 32'd0) begin
							upd.phase = PH_DATA;
						end else begin
							have = 1'b1;
							res.kind = KIND_EMPTY;
							res.entry_complete = 1'b1;
							upd.cur = cur_inc;
							upd.phase = close_phase;
						end
					end
				end
			end
			PH_NAME: begin
				have = 1'b1;
				res.kind = KIND_NAME;
				res.byte_value = in_byte;
				upd.left = left_dec;
				if (left_dec == 32'd0) begin
					res.field_last = 1'b1;
					upd.phase = PH_DATA_LEN;
				end
			end
			PH_DATA: begin
				have = 1'b1;
				res.kind = KIND_DATA;
				res.byte_value = in_byte;
				upd.left = left_dec;
				if (left_dec == 32'd0) begin
					res.field_last = 1'b1;
					res.entry_complete = 1'b1;
					upd.cur = cur_inc;
					upd.phase = close_phase;
				end
			end
			default: begin
			end
		endcase

		res.emit = have | end_of_buffer;
		res.finished = end_of_buffer;
		res.finish_status = ST_COMPLETE;
		if (end_of_buffer) begin
			unique case (upd.phase) inside
				PH_COUNT: res.finish_status = ST_SHORT;
				PH_NAME_LEN, PH_NAME, PH_DATA_LEN, PH_DATA: res.finish_status = ST_TRUNCATED;
				default: res.finish_status = ST_COMPLETE;
			endcase
			if (!have) begin
				res.entry_index = upd.cur;
			end
		end

		nxt = end_of_buffer ? StateReset : upd;
	end

endmodule

/* tb/length_prefixed_bundle_deframer_tb.sv */
module length_prefixed_bundle_deframer_tb
	import lpbd_pkg::*;
();

	localparam int ItemTarget = 1900;
	localparam int StallLimit = 2000;
	localparam int LongHoldCycles = 300;

	class bundle_checker;
		phase_t      phase;
		logic [31:0] acc;
		logic [1:0]  pos;
		logic [31:0] left;
		logic [31:0] total;
		logic [31:0] cur;
		result_t     expected_beats[$];
		int          errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			phase = PH_COUNT;
			acc   = '0;
			pos   = '0;
			left  = '0;
			total = '0;
			cur   = '0;
		endfunction

		function void close_entry();
			cur   = cur + 1;
			phase = (cur == total) ? PH_DONE : PH_NAME_LEN;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function void note_byte(input logic [7:0] b, input logic eob);
			result_t     r;
			logic        have;
			logic [31:0] w;
			r = '0;
			r.emit = 1'b1;
			r.kind = KIND_FINISH;
			r.finish_status = ST_COMPLETE;
			r.entry_index = cur;
			have = 1'b0;
			case (phase) inside
				PH_COUNT, PH_NAME_LEN, PH_DATA_LEN: begin
					acc = acc | ({24'd0, b} << (8 * pos));
					pos = pos + 2'd1;
					if (pos == 2'd0) begin
						w   = acc;
						acc = '0;
						if (phase == PH_COUNT) begin
							total = w;
							cur   = '0;
							phase = (w != 0) ? PH_NAME_LEN : PH_DONE;
						end else if (phase == PH_NAME_LEN) begin
							left  = w;
							phase = (w != 0) ? PH_NAME : PH_DATA_LEN;
						end else begin
							left = w;
							if (w != 0) begin
								phase = PH_DATA;
							end else begin
								have = 1'b1;
								r.kind = KIND_EMPTY;
								r.entry_complete = 1'b1;
								close_entry();
							end
						end
					end
				end
				PH_NAME: begin
					have = 1'b1;
					r.kind = KIND_NAME;
					r.byte_value = b;
					left = left - 1;
					if (left == 0) begin
						r.field_last = 1'b1;
						phase = PH_DATA_LEN;
					end
				end
				PH_DATA: begin
					have = 1'b1;
					r.kind = KIND_DATA;
					r.byte_value = b;
					left = left - 1;
					if (left == 0) begin
						r.field_last = 1'b1;
						r.entry_complete = 1'b1;
						close_entry();
					end
				end
				default: ;
			endcase
			if (eob) begin
				r.finished = 1'b1;
				if (phase == PH_COUNT)
					r.finish_status = ST_SHORT;
				else if (phase == PH_NAME_LEN || phase == PH_NAME ||
						phase == PH_DATA_LEN || phase == PH_DATA)
					r.finish_status = ST_TRUNCATED;
				if (!have)
					r.entry_index = cur;
			end
			if (have || eob)
				expected_beats.push_back(r);
			if (eob)
				restart();
		endfunction

		function void compare_field(input string field, input logic [31:0] exp_v,
				input logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0h, got %0h", field, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_beat(input logic [47:0] data, input logic [3:0] user,
				input logic last);
			result_t r;
			if (expected_beats.size() == 0) begin
				$error("output beat with nothing expected: tdata %0h tuser %0h", data, user);
				errors++;
				return;
			end
			r = expected_beats.pop_front();
			compare_field("kind", 32'(r.kind), 32'(user[1:0]));
			compare_field("byte_value", 32'(r.byte_value), 32'(data[7:0]));
			compare_field("entry_index", r.entry_index, data[39:8]);
			compare_field("field_last", 32'(r.field_last), 32'(user[2]));
			compare_field("entry_complete", 32'(r.entry_complete), 32'(user[3]));
			compare_field("finished", 32'(r.finished), 32'(last));
			compare_field("finish_status", 32'(r.finish_status), 32'(data[41:40]));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	bundle_checker chk;
	logic [7:0]    bundle_bytes[$];
	int            bytes_sent = 0;
	int            idle_cycles = 0;
	bit            tx_idle_on = 1'b1;
	bit            rx_idle_on = 1'b1;
	bit            long_hold_done = 1'b0;

	length_prefixed_bundle_deframer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void push_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			bundle_bytes.push_back(w[8 * i +: 8]);
	endfunction

	function automatic void push_random(input int count);
		repeat (count)
			bundle_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic int pick_len(input int longest);
		return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, longest);
	endfunction

	// mostly well-formed bundles, some with a wrong count, some cut short, some noise
	function automatic void build_random_bundle();
		int          mode;
		int          n;
		int          nl;
		int          dl;
		int          cut;
		logic [31:0] count_word;
		bundle_bytes.delete();
		mode = $urandom_range(0, 19);
		if (mode < 2) begin
			push_random($urandom_range(1, 14));
			return;
		end
		n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
		count_word = n;
		if (mode == 2)
			count_word = $urandom_range(0, 1) ? 32'hFFFF_FFFF : n + $urandom_range(1, 100);
		push_word(count_word);
		for (int e = 0; e < n; e++) begin
			nl = pick_len(6);
			dl = pick_len(8);
			push_word(nl);
			push_random(nl);
			push_word(dl);
			push_random(dl);
		end
		if ($urandom_range(0, 3) == 0)
			push_random($urandom_range(1, 3));
		if (mode == 3 || mode == 4) begin
			cut = $urandom_range(1, bundle_bytes.size());
			while (bundle_bytes.size() > cut)
				void'(bundle_bytes.pop_back());
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap(tx_idle_on);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		chk.note_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_bundle();
		foreach (bundle_bytes[i])
			send_byte(bundle_bytes[i], i == bundle_bytes.size() - 1);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (chk.pending() != 0);
	endtask

	// sink side: random stalls, plus one long hold while the source keeps pushing
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = pick_gap(rx_idle_on);
			if (!long_hold_done && bytes_sent >= 700) begin
				long_hold_done = 1'b1;
				stall = LongHoldCycles;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				rx_idle_on = !rx_idle_on;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			chk.check_beat(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= StallLimit) begin
					$display("FAIL length_prefixed_bundle_deframer");
					$finish;
				end
			end
		end
	end

	initial begin
		int bundles;
		chk = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero count, then a trailing byte as the final one
		bundle_bytes.delete();
		push_word(32'd0);
		bundle_bytes.push_back(8'hFF);
		send_bundle();
		// final byte inside the count header
		bundle_bytes.delete();
		bundle_bytes.push_back(8'h00);
		send_bundle();
		// empty name with one data byte, then a one-byte name with empty data
		bundle_bytes.delete();
		push_word(32'd2);
		push_word(32'd0);
		push_word(32'd1);
		bundle_bytes.push_back(8'hFF);
		push_word(32'd1);
		bundle_bytes.push_back(8'h00);
		push_word(32'd0);
		send_bundle();
		drain();

		bundles = 0;
		while (bytes_sent < ItemTarget) begin
			build_random_bundle();
			tx_idle_on = ($urandom_range(0, 3) != 0);
			send_bundle();
			bundles++;
			if (bundles == 60)
				drain();
		end
		drain();
		repeat (20) @(posedge clk);
		if (chk.errors == 0 && chk.pending() == 0) begin
			$display("PASS length_prefixed_bundle_deframer");
		end else begin
			$display("FAIL length_prefixed_bundle_deframer");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/lpbd_pkg.sv
hdl/lpbd_step.sv
hdl/length_prefixed_bundle_deframer.sv
tb/length_prefixed_bundle_deframer_tb.sv
